### design/irpa_pkg.sv
// ----------------------------------------------------------------------------
// irpa_pkg
// shared types, sizes and helpers for the increasing run pile assigner
// ----------------------------------------------------------------------------
package irpa_pkg;

    localparam int NUM_SEQ = 256;
    localparam int IDX_W   = (NUM_SEQ > 1) ? $clog2(NUM_SEQ) : 1;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic [31:0] value;
        logic        restart;
    } t_in_item;

    typedef struct packed {
        logic [7:0] seq_index;
        logic       opened_new;
        logic       overflow;
    } t_out_item;

    // packet that walks down the cell chain, one cell per cycle while the chain advances
    typedef struct packed {
        logic        active;     // an item occupies this slot
        logic        searching;  // no sequence found yet
        logic        clear;      // restart sweep still closing cells
        logic [31:0] value;
        logic [7:0]  seq_index;
        logic        opened_new;
    } t_pkt;

    // low 8 bits of a cell index, zero extended when the index is narrower
    function automatic logic [7:0] to_seq_index(input t_idx idx);
        logic [IDX_W+7:0] ext;
        ext = {8'b0, idx};
        return ext[7:0];
    endfunction

endpackage

### design/irpa_cell.sv
// ----------------------------------------------------------------------------
// irpa_cell
// one sequence slot: holds a tail and an open flag, resolves or forwards
// ----------------------------------------------------------------------------
module irpa_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  irpa_pkg::t_idx i_index,
    input  irpa_pkg::t_pkt i_pkt,
    output irpa_pkg::t_pkt o_pkt
);
    import irpa_pkg::*;

    logic        r_open;
    logic        n_open;
    logic [31:0] r_tail;
    logic [31:0] n_tail;
    t_pkt        r_pkt;
    t_pkt        n_pkt;

    logic clear_now;
    logic open_eff;
    logic seek;

    assign clear_now = i_pkt.active && i_pkt.clear;
    assign open_eff  = r_open && !clear_now;
    assign seek      = i_pkt.active && i_pkt.searching;

    always_comb begin
        n_open = open_eff;
        n_tail = r_tail;
        n_pkt  = i_pkt;
        if (seek) begin
            if (!open_eff) begin
                // first closed slot: start a new sequence here
                n_open           = 1'b1;
                n_tail           = i_pkt.value;
                n_pkt.searching  = 1'b0;
                n_pkt.opened_new = 1'b1;
                n_pkt.seq_index  = to_seq_index(i_index);
            end else if (r_tail <= i_pkt.value) begin
                n_tail           = i_pkt.value;
                n_pkt.searching  = 1'b0;
                n_pkt.opened_new = 1'b0;
                n_pkt.seq_index  = to_seq_index(i_index);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_pkt  <= '0;
        end else if (i_en) begin
            r_open <= n_open;
            r_pkt  <= n_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tail <= n_tail;
        end
    end

    assign o_pkt = r_pkt;

    // a slot only opens when a searching item passes through it
    a_open_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_open) |-> $past(i_en && i_pkt.active && i_pkt.searching))
        else $error("cell opened without a searching item");

    // a searching item reaching a closed slot settles there as a new sequence
    a_closed_slot_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && seek && !open_eff) |=>
            (r_open && r_pkt.active && !r_pkt.searching && r_pkt.opened_new))
        else $error("closed cell did not take searching item");

    // an open slot with a larger tail forwards the item and keeps its tail
    a_larger_tail_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && seek && open_eff && (r_tail > i_pkt.value)) |=>
            (r_pkt.searching && $stable(r_tail)))
        else $error("cell with larger tail captured item");

endmodule

### design/increasing_run_pile_assigner_core.sv
// ----------------------------------------------------------------------------
// increasing_run_pile_assigner_core
// greedy split of a value stream into increasing sequences on a cell chain
// ----------------------------------------------------------------------------
// Each value walks down a chain of NUM_SEQ cells, one cell per cycle. Cell i
// holds the tail of sequence i; the first open cell whose tail is not greater
// than the value takes it, and the first closed cell reached opens a new
// sequence. A value that passes every cell is dropped and reported as
// overflow. A restart item closes every cell as it sweeps past, so items
// behind it see the cleared set while items ahead are untouched. Results keep
// riding the chain to its end, so they come out in input order. Each result
// passes every cell register and then the output register; a new transfer is
// taken every cycle while the result side keeps up, the whole chain and the
// output register moving together. A result stall freezes the chain, which
// shows up at the input as stall. No clearing pass follows reset: the open
// flags are reset and the tails are only read once written.
// ----------------------------------------------------------------------------
module increasing_run_pile_assigner_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  irpa_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output irpa_pkg::t_out_item o_out_data
);
    import irpa_pkg::*;

    // packets between cells: stage 0 is the input, stage NUM_SEQ the chain end
    t_pkt      chain [NUM_SEQ+1];
    logic      advance;

    logic      r_out_valid;
    t_out_item r_out_data;
    t_out_item n_out_data;

    // the chain moves whenever the output register is free or being emptied
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = !advance;

    // build the entry packet from the input transfer
    always_comb begin
        chain[0].active     = i_in_valid;
        chain[0].searching  = 1'b1;
        chain[0].clear      = i_in_data.restart;
        chain[0].value      = i_in_data.value;
        chain[0].seq_index  = 8'd0;
        chain[0].opened_new = 1'b0;
    end

    for (genvar g = 0; g < NUM_SEQ; g++) begin : g_cell
        irpa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_index (t_idx'(g)),
            .i_pkt   (chain[g]),
            .o_pkt   (chain[g+1])
        );
    end

    // an item still searching at the chain end found no free slot
    always_comb begin
        if (chain[NUM_SEQ].searching) begin
            n_out_data.seq_index  = 8'd0;
            n_out_data.opened_new = 1'b0;
            n_out_data.overflow   = 1'b1;
        end else begin
            n_out_data.seq_index  = chain[NUM_SEQ].seq_index;
            n_out_data.opened_new = chain[NUM_SEQ].opened_new;
            n_out_data.overflow   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= chain[NUM_SEQ].active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a dropped value reports no sequence
    a_overflow_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.overflow) |->
            (!r_out_data.opened_new && (r_out_data.seq_index == 8'd0)))
        else $error("overflow result carries a sequence");

    // the input only stalls behind a pending result
    a_stall_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled without a pending result");

    // a pending result that is not taken stays valid for the next cycle
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("pending result lost");

endmodule
